// ===== rtl/lcc_pkg.sv =====
// Shared types and constants for the Luhn card number classifier.
package lcc_pkg;

  localparam int CARD_W  = 63;
  localparam int DIGIT_W = 4;
  localparam int COUNT_W = 5;
  localparam int PAIR_W  = 7;
  localparam int KIND_W  = 2;
  localparam int SUM_W   = 4;

  // Card kind codes.
  localparam logic [KIND_W-1:0] KIND_INVALID = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PFX_3X  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PFX_5X  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_PFX_4X  = 2'd3;

  // Running Luhn state handed from one digit cell to the next.
  typedef struct packed {
    logic [SUM_W-1:0]   sum;    // Luhn sum modulo ten
    logic [COUNT_W-1:0] count;  // position of the highest nonzero digit plus one
    logic [DIGIT_W-1:0] hi;     // highest nonzero digit seen so far
    logic [DIGIT_W-1:0] lo;     // digit just below it
  } luhn_acc_t;

endpackage

// ===== rtl/lcc_dabble_cell.sv =====
// One shift-add-3 cell of the binary to BCD conversion chain.
module lcc_dabble_cell #(
  parameter int NDIG = 19
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [lcc_pkg::CARD_W-1:0]     in_bin,
  input  logic [NDIG*lcc_pkg::DIGIT_W-1:0] in_bcd,
  output logic                           out_valid,
  output logic [lcc_pkg::CARD_W-1:0]     out_bin,
  output logic [NDIG*lcc_pkg::DIGIT_W-1:0] out_bcd
);
  import lcc_pkg::*;

  localparam int BCD_W = NDIG * DIGIT_W;

  logic [BCD_W-1:0] adj;

  // Add three to every digit of five or more so that the shift doubles in decimal.
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (in_bcd[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        adj[i*DIGIT_W +: DIGIT_W] = in_bcd[i*DIGIT_W +: DIGIT_W] + 4'd3;
      end else begin
        adj[i*DIGIT_W +: DIGIT_W] = in_bcd[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  // Shift the next binary bit in; the carry out of the top digit is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_bcd <= {adj[BCD_W-2:0], in_bin[CARD_W-1]};
      out_bin <= {in_bin[CARD_W-2:0], 1'b0};
    end
  end

endmodule

// ===== rtl/lcc_luhn_cell.sv =====
// One digit cell of the Luhn chain: folds one decimal digit into the running state.
module lcc_luhn_cell #(
  parameter int NDIG = 19,
  parameter int POS  = 0
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [NDIG*lcc_pkg::DIGIT_W-1:0] in_bcd,
  input  lcc_pkg::luhn_acc_t               in_acc,
  output logic                             out_valid,
  output logic [NDIG*lcc_pkg::DIGIT_W-1:0] out_bcd,
  output lcc_pkg::luhn_acc_t               out_acc
);
  import lcc_pkg::*;

  localparam int PREV = (POS > 0) ? POS - 1 : 0;

  logic [DIGIT_W-1:0] dig;
  logic [DIGIT_W-1:0] prev_dig;
  logic [DIGIT_W:0]   dbl;
  logic [DIGIT_W-1:0] term;
  logic [SUM_W:0]     sum_raw;
  luhn_acc_t          acc_next;

  assign dig      = in_bcd[POS*DIGIT_W +: DIGIT_W];
  assign prev_dig = (POS > 0) ? in_bcd[PREV*DIGIT_W +: DIGIT_W] : '0;
  assign dbl      = {dig, 1'b0};

  // Digits in odd positions from the right are doubled and their digits summed.
  always_comb begin
    if ((POS % 2) == 1) begin
      term = (dbl > 5'd9) ? DIGIT_W'(dbl - 5'd9) : dbl[DIGIT_W-1:0];
    end else begin
      term = dig;
    end
  end

  // Accumulate modulo ten and track the leading nonzero digit and its neighbor.
  always_comb begin
    acc_next = in_acc;
    sum_raw  = {1'b0, in_acc.sum} + {1'b0, term};
    acc_next.sum = (sum_raw >= 5'd10) ? SUM_W'(sum_raw - 5'd10) : sum_raw[SUM_W-1:0];
    if (dig != '0) begin
      acc_next.count = COUNT_W'(POS + 1);
      acc_next.hi    = dig;
      acc_next.lo    = prev_dig;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_bcd <= in_bcd;
      out_acc <= acc_next;
    end
  end

endmodule

// ===== rtl/luhn_card_number_classifier_unit.sv =====
// Pipeline: 63 conversion cells, MAX_DIGITS Luhn cells and one output register.
// Throughput: one transaction per cycle; every cell advances together unless the output stalls.
// The binary to BCD conversion is a chain of 63 shift-add-3 cells, one per input bit.
// The Luhn check is a chain of MAX_DIGITS cells, one per decimal digit.
// Reset (rst, synchronous, active high) clears every stage valid bit and the output valid.
// Top level of the Luhn card number classifier.
module luhn_card_number_classifier_unit #(
  parameter int MAX_DIGITS = 19
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [62:0] card_value, [63] zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [1:0] card_kind, [2] luhn_ok, [7:3] digit_count,
                                 // [14:8] leading_pair, [15] zero pad
);
  import lcc_pkg::*;

  localparam int BCD_W = MAX_DIGITS * DIGIT_W;

  logic                en;
  logic                dab_valid [0:CARD_W];
  logic [CARD_W-1:0]   dab_bin   [0:CARD_W];
  logic [BCD_W-1:0]    dab_bcd   [0:CARD_W];
  logic                lu_valid  [0:MAX_DIGITS];
  logic [BCD_W-1:0]    lu_bcd    [0:MAX_DIGITS];
  luhn_acc_t           lu_acc    [0:MAX_DIGITS];

  luhn_acc_t           fin;
  logic                ok;
  logic [PAIR_W-1:0]   pair;
  logic [KIND_W-1:0]   kind;

  // The whole chain advances whenever the output register can take a value.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  assign dab_valid[0] = s_tvalid;
  assign dab_bin[0]   = s_tdata[CARD_W-1:0];
  assign dab_bcd[0]   = '0;

  // Binary to BCD conversion chain.
  for (genvar k = 0; k < CARD_W; k++) begin : g_dab
    lcc_dabble_cell #(.NDIG(MAX_DIGITS)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (dab_valid[k]),
      .in_bin    (dab_bin[k]),
      .in_bcd    (dab_bcd[k]),
      .out_valid (dab_valid[k+1]),
      .out_bin   (dab_bin[k+1]),
      .out_bcd   (dab_bcd[k+1])
    );
  end

  assign lu_valid[0] = dab_valid[CARD_W];
  assign lu_bcd[0]   = dab_bcd[CARD_W];
  assign lu_acc[0]   = '0;

  // Luhn chain, least significant digit first.
  for (genvar p = 0; p < MAX_DIGITS; p++) begin : g_luhn
    lcc_luhn_cell #(.NDIG(MAX_DIGITS), .POS(p)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (lu_valid[p]),
      .in_bcd    (lu_bcd[p]),
      .in_acc    (lu_acc[p]),
      .out_valid (lu_valid[p+1]),
      .out_bcd   (lu_bcd[p+1]),
      .out_acc   (lu_acc[p+1])
    );
  end

  // Final classification from the leading pair, digit count and Luhn flag.
  assign fin = lu_acc[MAX_DIGITS];
  assign ok  = (fin.sum == '0);

  always_comb begin
    if (fin.count >= 5'd2) begin
      pair = PAIR_W'(fin.hi) * 7'd10 + PAIR_W'(fin.lo);
    end else begin
      pair = '0;
    end
  end

  always_comb begin
    kind = KIND_INVALID;
    if (ok) begin
      priority if (fin.count == 5'd15 && (pair == 7'd34 || pair == 7'd37)) begin
        kind = KIND_PFX_3X;
      end else if (fin.count == 5'd16 && pair >= 7'd51 && pair <= 7'd55) begin
        kind = KIND_PFX_5X;
      end else if ((fin.count == 5'd13 || fin.count == 5'd16) &&
                   pair >= 7'd40 && pair <= 7'd49) begin
        kind = KIND_PFX_4X;
      end else begin
        kind = KIND_INVALID;
      end
    end
  end

  // Output register between the chain and the downstream side; m_tready reaches the chain enable combinationally.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= lu_valid[MAX_DIGITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {1'b0, pair, fin.count, ok, kind};
    end
  end

`ifndef NO_ASSERTIONS
  a_kind_needs_luhn : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[2] |-> m_tdata[1:0] == KIND_INVALID)
    else $error("card kind set on a number that fails the Luhn check");

  a_count_range : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:3] <= 5'(MAX_DIGITS))
    else $error("digit count exceeds converter width");

  a_kind3x_len : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == KIND_PFX_3X |-> m_tdata[7:3] == 5'd15)
    else $error("prefix 3x kind with a length other than 15");

  a_short_pair : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[7:3] < 5'd2 |-> m_tdata[14:8] == '0)
    else $error("leading pair nonzero on a number of fewer than two digits");

  a_reset_clears : assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");
`endif

endmodule
